/* rtl/ppse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppse_pkg
// Shared types and field widths for the priority schedule evaluator.
// ----------------------------------------------------------------------------
package ppse_pkg;

  localparam int ARR_W   = 16;
  localparam int BURST_W = 16;
  localparam int PRI_W   = 8;
  localparam int WAIT_W  = 20;
  localparam int TAT_W   = 21;
  localparam int IDX_W   = 4;

  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SCAN_END,
    ST_EXEC,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // input transfer
    logic start;     // input transfer carrying the last flag
    logic scan_rd;   // read next entry for the priority scan
    logic exec;      // apply the scan outcome
    logic emit_rd;   // read next entry for a result
    logic out_load;  // fill the output register
    logic clear;     // set finished, drop the loaded processes
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_last;
    logic last_finish;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/preemptive_priority_schedule_eval.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_schedule_eval
// Loads a set of processes, runs a preemptive priority schedule over it and
// returns waiting and turnaround time for each process in load order.
//
//   Channel  Dir  Transfer payload
//   s_axis   in   one process; tlast closes the set and starts the run
//   m_axis   out  one result per process; tlast on the final one
//
// Loading accepts one process per cycle. After the closing transfer, each
// scheduling step (up to the next arrival or completion) reads all n loaded
// processes, drains the last read and applies one update; there are at most 2n
// steps. Each result is read, then loaded into the output register when free.
// s_axis_tready is low from the closing transfer until the last result is in
// the output register. Reset clears control only; stores are rewritten per set.
// ----------------------------------------------------------------------------
module preemptive_priority_schedule_eval #(
  parameter int MAX_PROCS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // arrival_time, burst_time, priority_level
  input  logic        s_axis_tlast,   // last_process
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // process_index, waiting_time, turnaround_time
  output logic        m_axis_tlast    // last_result
);

  ppse_pkg::cmd_t    cmd;
  ppse_pkg::status_t status;

  logic [ppse_pkg::IDX_W-1:0]  process_index;
  logic [ppse_pkg::WAIT_W-1:0] waiting_time;
  logic [ppse_pkg::TAT_W-1:0]  turnaround_time;

  ppse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ppse_dp #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .arrival_time    (s_axis_tdata[15:0]),
    .burst_time      (s_axis_tdata[31:16]),
    .priority_level  (s_axis_tdata[39:32]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .process_index   (process_index),
    .waiting_time    (waiting_time),
    .turnaround_time (turnaround_time),
    .last_result     (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, turnaround_time, waiting_time, process_index};

endmodule

/* rtl/ppse_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppse_ctrl
// Sequencer: load, scan/execute loop, then result emission.
// ----------------------------------------------------------------------------
module ppse_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  ppse_pkg::status_t  status,
  output ppse_pkg::cmd_t     cmd
);

  ppse_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppse_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ppse_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            cmd.start  = 1'b1;
            state_next = ppse_pkg::ST_SCAN;
          end
        end
      end
      ppse_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.idx_last) begin
          state_next = ppse_pkg::ST_SCAN_END;
        end
      end
      // last read data is evaluated here
      ppse_pkg::ST_SCAN_END: begin
        state_next = ppse_pkg::ST_EXEC;
      end
      ppse_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.last_finish) begin
          state_next = ppse_pkg::ST_EMIT_RD;
        end else begin
          state_next = ppse_pkg::ST_SCAN;
        end
      end
      ppse_pkg::ST_EMIT_RD: begin
        if (status.out_free) begin
          cmd.emit_rd = 1'b1;
          state_next  = ppse_pkg::ST_EMIT_LD;
        end
      end
      ppse_pkg::ST_EMIT_LD: begin
        cmd.out_load = 1'b1;
        if (status.emit_last) begin
          cmd.clear  = 1'b1;
          state_next = ppse_pkg::ST_LOAD;
        end else begin
          state_next = ppse_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ppse_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

/* rtl/ppse_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppse_dp
// Process stores, scan registers, tick counter and output register.
// ----------------------------------------------------------------------------
module ppse_dp #(
  parameter int MAX_PROCS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ppse_pkg::cmd_t                  cmd,
  output ppse_pkg::status_t               status,
  input  logic [ppse_pkg::ARR_W-1:0]      arrival_time,
  input  logic [ppse_pkg::BURST_W-1:0]    burst_time,
  input  logic [ppse_pkg::PRI_W-1:0]      priority_level,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ppse_pkg::IDX_W-1:0]      process_index,
  output logic [ppse_pkg::WAIT_W-1:0]     waiting_time,
  output logic [ppse_pkg::TAT_W-1:0]      turnaround_time,
  output logic                            last_result
);

  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int AW     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  // finish tick never exceeds (MAX_PROCS + 1) * 65535
  localparam int TICK_W = ppse_pkg::BURST_W + $clog2(MAX_PROCS + 2);
  localparam int DIFF_W = (TICK_W > ppse_pkg::TAT_W) ? TICK_W : ppse_pkg::TAT_W;
  localparam int ENT_W  = ppse_pkg::PRI_W + ppse_pkg::BURST_W + ppse_pkg::ARR_W;

  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  // stores
  logic [ENT_W-1:0]               proc_mem [MAX_PROCS];
  logic [ppse_pkg::BURST_W-1:0]   rem_mem  [MAX_PROCS];
  logic [ppse_pkg::WAIT_W-1:0]    wait_mem [MAX_PROCS];

  logic [ENT_W-1:0]               proc_q;
  logic [ppse_pkg::BURST_W-1:0]   rem_q;
  logic [ppse_pkg::WAIT_W-1:0]    wait_q;
  logic [CNT_W-1:0]               rd_idx_q;

  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               completed;
  logic [CNT_W-1:0]               idx;
  logic [TICK_W-1:0]              tick;
  logic                           scan_vld;

  // scan results
  logic                           found;
  logic                           have_next;
  logic [ppse_pkg::PRI_W-1:0]     best_pri;
  logic [ppse_pkg::BURST_W-1:0]   best_rem;
  logic [ppse_pkg::ARR_W-1:0]     best_arr;
  logic [ppse_pkg::BURST_W-1:0]   best_burst;
  logic [AW-1:0]                  pick;
  logic [ppse_pkg::ARR_W-1:0]     next_arr;

  logic                           full;
  logic                           load_wr;
  logic [ppse_pkg::BURST_W-1:0]   burst_fix;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;

  logic [ppse_pkg::ARR_W-1:0]     q_arr;
  logic [ppse_pkg::BURST_W-1:0]   q_burst;
  logic [ppse_pkg::PRI_W-1:0]     q_pri;
  logic                           arrived;
  logic                           take;
  logic                           sooner;

  logic [TICK_W-1:0]              gap;
  logic                           finish;
  logic [ppse_pkg::BURST_W-1:0]   run_len;
  logic [TICK_W-1:0]              tick_step;
  logic [DIFF_W-1:0]              used;
  logic [DIFF_W-1:0]              fin;
  logic [DIFF_W-1:0]              wdiff;
  logic [ppse_pkg::WAIT_W-1:0]    wait_val;

  logic                           rem_we;
  logic [AW-1:0]                  rem_waddr;
  logic [ppse_pkg::BURST_W-1:0]   rem_wdata;
  logic                           wait_we;
  logic [CNT_W+ppse_pkg::IDX_W-1:0] idx_ext;

  assign full      = (count == CNT_MAX);
  assign load_wr   = cmd.load && !full;
  assign burst_fix = (burst_time == '0) ? ppse_pkg::BURST_W'(1) : burst_time;
  assign rd_en     = cmd.scan_rd || cmd.emit_rd;
  assign rd_addr   = idx[AW-1:0];

  assign q_arr   = proc_q[ppse_pkg::ARR_W-1:0];
  assign q_burst = proc_q[ppse_pkg::ARR_W +: ppse_pkg::BURST_W];
  assign q_pri   = proc_q[ppse_pkg::ARR_W+ppse_pkg::BURST_W +: ppse_pkg::PRI_W];

  // strict compare keeps ties on the lower index
  assign arrived = (TICK_W'(q_arr) <= tick);
  assign take    = arrived && (rem_q != '0) && (!found || (q_pri < best_pri));
  assign sooner  = !arrived && (!have_next || (q_arr < next_arr));

  // run the picked process up to its end or the next arrival
  assign gap       = TICK_W'(next_arr) - tick;
  assign finish    = !have_next || (gap >= TICK_W'(best_rem));
  assign run_len   = finish ? best_rem : gap[ppse_pkg::BURST_W-1:0];
  assign tick_step = tick + TICK_W'(run_len);

  // wait only matters on completion, where the run covers all of best_rem
  assign used  = DIFF_W'(best_burst) + DIFF_W'(best_arr);
  assign fin   = DIFF_W'(tick) + DIFF_W'(best_rem);
  assign wdiff = (fin > used) ? (fin - used) : '0;
  assign wait_val = (wdiff > DIFF_W'(ppse_pkg::WAIT_MAX)) ? ppse_pkg::WAIT_MAX
                                                          : wdiff[ppse_pkg::WAIT_W-1:0];

  assign rem_we    = load_wr || (cmd.exec && found);
  assign rem_waddr = load_wr ? count[AW-1:0] : pick;
  assign rem_wdata = load_wr ? burst_fix : (best_rem - run_len);
  assign wait_we   = cmd.exec && found && finish;

  assign status.idx_last    = (idx == count - CNT_ONE);
  assign status.last_finish = found && finish && (completed == count - CNT_ONE);
  assign status.emit_last   = (rd_idx_q == count - CNT_ONE);
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (load_wr) begin
      proc_mem[count[AW-1:0]] <= {priority_level, burst_fix, arrival_time};
    end
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    if (wait_we) begin
      wait_mem[pick] <= wait_val;
    end
    if (rd_en) begin
      proc_q   <= proc_mem[rd_addr];
      rem_q    <= rem_mem[rd_addr];
      wait_q   <= wait_mem[rd_addr];
      rd_idx_q <= idx;
    end
  end

  // counters and tick
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      completed <= '0;
      idx       <= '0;
      tick      <= '0;
      scan_vld  <= 1'b0;
    end else begin
      scan_vld <= cmd.scan_rd;
      if (cmd.clear) begin
        count <= '0;
      end else if (load_wr) begin
        count <= count + CNT_ONE;
      end
      if (cmd.start || cmd.exec) begin
        idx <= '0;
      end else if (rd_en) begin
        idx <= idx + CNT_ONE;
      end
      if (cmd.start) begin
        tick      <= '0;
        completed <= '0;
      end else if (cmd.exec) begin
        if (found) begin
          tick <= tick_step;
          if (finish) begin
            completed <= completed + CNT_ONE;
          end
        end else begin
          tick <= TICK_W'(next_arr);
        end
      end
    end
  end

  // priority scan, one entry per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      have_next <= 1'b0;
    end else if (cmd.start || cmd.exec) begin
      found     <= 1'b0;
      have_next <= 1'b0;
    end else if (scan_vld) begin
      if (take) begin
        found <= 1'b1;
      end
      if (sooner) begin
        have_next <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_vld && take) begin
      best_pri   <= q_pri;
      best_rem   <= rem_q;
      best_arr   <= q_arr;
      best_burst <= q_burst;
      pick       <= rd_idx_q[AW-1:0];
    end
    if (scan_vld && sooner) begin
      next_arr <= q_arr;
    end
  end

  // output register
  assign idx_ext = {{ppse_pkg::IDX_W{1'b0}}, rd_idx_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      process_index   <= idx_ext[ppse_pkg::IDX_W-1:0];
      waiting_time    <= wait_q;
      turnaround_time <= ppse_pkg::TAT_W'(q_burst) + ppse_pkg::TAT_W'(wait_q);
      last_result     <= status.emit_last;
    end
  end

endmodule

/* rtl/ppse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppse_checker
// Port-level checks for the priority schedule evaluator.
// ----------------------------------------------------------------------------
module ppse_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // comes out of reset empty and ready to load
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("not idle after reset");

  // closing transfer stops further loading while the set runs
  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input accepted after the closing transfer");

  // a result other than the final one only appears while loading is held off
  a_emit_exclusive: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("loading open while a set is still being emitted");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind preemptive_priority_schedule_eval ppse_checker u_ppse_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

/* test/ppse_schedule_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppse_schedule_checker
// Watches both stream channels of the priority schedule evaluator. It keeps
// its own copy of the loaded process set and, on the closing transfer, works
// out the preemptive priority schedule. The per-process waiting and
// turnaround times go into a queue, and each result transfer is compared
// field by field against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module ppse_schedule_checker
  import ppse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // arrival_time, burst_time, priority_level
  input  logic        s_axis_tlast,   // last_process
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // process_index, waiting_time, turnaround_time
  input  logic        m_axis_tlast,   // last_result
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int     SET_DEPTH = 16;
  localparam longint WAIT_CAP  = (longint'(1) << WAIT_W) - 1;
  localparam longint TAT_CAP   = (longint'(1) << TAT_W) - 1;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [WAIT_W-1:0] waiting;
    logic [TAT_W-1:0]  turnaround;
    logic              final_flag;
  } sched_result_t;

  logic [ARR_W-1:0]   arrival_tbl [SET_DEPTH];
  logic [BURST_W-1:0] burst_tbl   [SET_DEPTH];
  logic [PRI_W-1:0]   prio_tbl    [SET_DEPTH];
  int                 loaded;
  int                 errors;
  int                 results_seen;
  sched_result_t      expected_results [$];

  initial begin
    fail_count   = 0;
    pending      = 0;
    checked      = 0;
    loaded       = 0;
    errors       = 0;
    results_seen = 0;
  end

  // Event-driven schedule: the choice of process only changes at an arrival
  // or a completion, so time jumps straight between those instants.
  task automatic schedule_loaded_set();
    longint        now_tick, next_arr, slice, used, w, tat;
    longint        left    [SET_DEPTH];
    longint        waiting [SET_DEPTH];
    int            finished, pick;
    bit            found, have_next;
    logic [PRI_W-1:0] best;
    sched_result_t r;
    now_tick = 0;
    finished = 0;
    for (int i = 0; i < loaded; i++) begin
      left[i]    = longint'(burst_tbl[i]);
      waiting[i] = 0;
    end
    while (finished < loaded) begin
      found     = 1'b0;
      have_next = 1'b0;
      pick      = 0;
      best      = '0;
      next_arr  = 0;
      for (int i = 0; i < loaded; i++) begin
        if (longint'(arrival_tbl[i]) <= now_tick) begin
          // strict compare keeps the lower index on a tie
          if (left[i] > 0 && (!found || prio_tbl[i] < best)) begin
            found = 1'b1;
            best  = prio_tbl[i];
            pick  = i;
          end
        end else if (!have_next || longint'(arrival_tbl[i]) < next_arr) begin
          have_next = 1'b1;
          next_arr  = longint'(arrival_tbl[i]);
        end
      end
      if (!found) begin
        now_tick = next_arr;
      end else begin
        slice = left[pick];
        if (have_next && next_arr - now_tick < slice)
          slice = next_arr - now_tick;
        now_tick   += slice;
        left[pick] -= slice;
        if (left[pick] == 0) begin
          used = longint'(burst_tbl[pick]) + longint'(arrival_tbl[pick]);
          w    = (now_tick > used) ? now_tick - used : 0;
          if (w > WAIT_CAP)
            w = WAIT_CAP;
          waiting[pick] = w;
          finished++;
        end
      end
    end
    for (int i = 0; i < loaded; i++) begin
      tat = longint'(burst_tbl[i]) + waiting[i];
      if (tat > TAT_CAP)
        tat = TAT_CAP;
      r.index      = i[IDX_W-1:0];
      r.waiting    = waiting[i][WAIT_W-1:0];
      r.turnaround = tat[TAT_W-1:0];
      r.final_flag = (i == loaded - 1);
      expected_results.push_back(r);
    end
    loaded = 0;
  endtask

  task automatic check_result();
    sched_result_t    exp_r;
    logic [IDX_W-1:0]  got_idx;
    logic [WAIT_W-1:0] got_wait;
    logic [TAT_W-1:0]  got_tat;
    logic [2:0]        got_pad;
    got_idx  = m_axis_tdata[IDX_W-1:0];
    got_wait = m_axis_tdata[IDX_W +: WAIT_W];
    got_tat  = m_axis_tdata[IDX_W+WAIT_W +: TAT_W];
    got_pad  = m_axis_tdata[47:45];
    results_seen++;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result transfer: idx %0d wait %0d tat %0d last %0b",
               $time, got_idx, got_wait, got_tat, m_axis_tlast);
    end else begin
      exp_r = expected_results.pop_front();
      if (got_idx !== exp_r.index || got_wait !== exp_r.waiting ||
          got_tat !== exp_r.turnaround || m_axis_tlast !== exp_r.final_flag ||
          got_pad !== 3'b000) begin
        errors++;
        $display("%0t: result mismatch: expected idx %0d wait %0d tat %0d last %0b pad 0",
                 $time, exp_r.index, exp_r.waiting, exp_r.turnaround, exp_r.final_flag);
        $display("%0t:                  actual   idx %0d wait %0d tat %0d last %0b pad %0d",
                 $time, got_idx, got_wait, got_tat, m_axis_tlast, got_pad);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      loaded = 0;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        // a full set drops the transfer but still honours its last flag
        if (loaded < SET_DEPTH) begin
          arrival_tbl[loaded] = s_axis_tdata[ARR_W-1:0];
          burst_tbl[loaded]   = (s_axis_tdata[ARR_W +: BURST_W] == '0) ?
                                BURST_W'(1) : s_axis_tdata[ARR_W +: BURST_W];
          prio_tbl[loaded]    = s_axis_tdata[ARR_W+BURST_W +: PRI_W];
          loaded++;
        end
        if (s_axis_tlast)
          schedule_loaded_set();
      end
    end
    fail_count <= errors;
    pending    <= expected_results.size();
    checked    <= results_seen;
  end

endmodule

/* test/preemptive_priority_schedule_eval_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preemptive_priority_schedule_eval_tb
// Drives process sets into the schedule evaluator: a directed opening with
// field extremes, preemption, ties, idle time, a zero burst and an overfull
// set, then random sets of mixed size and spread. Both channels idle at
// random, and the result side holds off for long stretches to back the
// block up. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module preemptive_priority_schedule_eval_tb;
  import ppse_pkg::*;

  localparam int ITEM_TARGET    = 480;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int HOLD_OFF       = 400;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata  = '0;   // arrival_time, burst_time, priority_level
  logic        s_axis_tlast  = 1'b0; // last_process
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // process_index, waiting_time, turnaround_time
  logic        m_axis_tlast;         // last_result

  int fail_count;
  int pending;
  int checked;
  int offered       = 0;
  int sets_sent     = 0;
  int overfull_sets = 0;
  int idle_cycles   = 0;
  bit sender_calm   = 1'b0;

  preemptive_priority_schedule_eval dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  ppse_schedule_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one; none at all when calm
  function automatic int idle_len(input bit calm);
    int r;
    if (calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 50)
      return 0;
    else if (r < 85)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_process(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                              input logic [PRI_W-1:0] prio, input bit last);
    int gap;
    gap = idle_len(sender_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {prio, burst, arr};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    offered++;
  endtask

  task automatic send_random_set();
    int size, r;
    bit narrow_arr, narrow_prio;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   prio;
    r = $urandom_range(0, 99);
    if (r < 70)
      size = $urandom_range(1, 6);
    else if (r < 90)
      size = $urandom_range(7, 16);
    else
      size = $urandom_range(17, 20);
    sender_calm = ($urandom_range(0, 3) == 0);
    // narrow ranges force contention, preemption and priority ties
    narrow_arr  = ($urandom_range(0, 9) < 7);
    narrow_prio = $urandom_range(0, 1);
    for (int j = 0; j < size; j++) begin
      arr = narrow_arr ? ARR_W'($urandom_range(0, 30)) : ARR_W'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 4)
        burst = '0;
      else if (r < 75)
        burst = BURST_W'($urandom_range(1, 8));
      else
        burst = BURST_W'($urandom_range(1, 65535));
      prio = narrow_prio ? PRI_W'($urandom_range(0, 3)) : PRI_W'($urandom_range(0, 255));
      send_process(arr, burst, prio, j == size - 1);
    end
    sets_sent++;
    if (size > 16)
      overfull_sets++;
  endtask

  // result side: random stalls, calm stretches, and two long hold-offs
  initial begin
    int stall;
    int served;
    bit calm;
    served = 0;
    calm   = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (served % 32 == 0)
        calm = ($urandom_range(0, 3) == 0);
      stall = idle_len(calm);
      if (served == 20 || served == 150)
        stall = HOLD_OFF;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      served++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("preemptive_priority_schedule_eval verification failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // single process at the top of every field
    send_process(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    // zero burst is raised to one tick
    send_process(16'h0000, 16'h0000, 8'h00, 1'b1);
    // preemption, equal-priority tie, late arrival after an idle stretch
    send_process(16'd0,  16'd10, 8'd5, 1'b0);
    send_process(16'd2,  16'd4,  8'd1, 1'b0);
    send_process(16'd2,  16'd4,  8'd1, 1'b0);
    send_process(16'd5,  16'd2,  8'd0, 1'b0);
    send_process(16'd40, 16'd3,  8'd9, 1'b1);
    sets_sent += 3;
    // overfull set: the seventeenth transfer is dropped but closes the set
    for (int j = 0; j < 17; j++)
      send_process(ARR_W'(j * 3), BURST_W'(j + 1), PRI_W'((j * 7) % 16), j == 16);
    sets_sent++;
    overfull_sets++;

    while (offered < ITEM_TARGET)
      send_random_set();
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d processes in %0d sets (%0d overfull, extremes, zero bursts, ties).",
             offered, sets_sent, overfull_sets);
    $display("Checked %0d results under random stalls and long result-side hold-offs.",
             checked);
    if (fail_count == 0)
      $display("preemptive_priority_schedule_eval verification clean");
    else
      $display("preemptive_priority_schedule_eval verification failed");
    $finish;
  end

endmodule
